### rtl/core/bsc_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear spring coefficients: shared definitions
// Widths, register indexes, stage records and the output saturation.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int COORD_W   = 24;  // Q8.16 coordinate
    localparam int DIFF_W    = 25;  // magnitude of a coordinate difference
    localparam int LEN_W     = 25;  // integer square root of SUM_W bits
    localparam int SQ_W      = 2 * LEN_W;
    localparam int SUM_W     = 2 * LEN_W;
    localparam int K_W       = 32;
    localparam int STR_W     = LEN_W + 1;
    localparam int NUM_W     = 64;
    localparam int OUT_W     = 32;
    localparam int AXES_W    = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_STIFFNESS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_STIFFNESS = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_STRETCH = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_COUNT     = CFG_IDX_W'(3);

    localparam logic [K_W-1:0]    RST_STIFFNESS = K_W'(65536);
    localparam logic [K_W-1:0]    RST_CUTOFF    = '0;
    localparam logic [AXES_W-1:0] RST_AXES      = AXES_W'(3);

    localparam logic [OUT_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] SAT_MIN = 32'h8000_0000;

    // x in element 0, y in 1, z in 2
    typedef logic [2:0][COORD_W-1:0] t_vec;

    typedef struct packed {
        logic             na_neg;
        logic [NUM_W-1:0] na_mag;
        logic             nd_neg;
        logic [NUM_W-1:0] nd_mag;
        logic [LEN_W-1:0] lcur;
        logic [SQ_W-1:0]  d2;
        logic             high;
        logic             zero;
    } t_numer;

    typedef struct packed {
        logic             nd_neg;
        logic [NUM_W-1:0] nd_mag;
        logic [SQ_W-1:0]  d2;
        logic             high;
        logic             zero;
        logic             na_neg;
    } t_side_a;

    typedef struct packed {
        logic [OUT_W-1:0] alpha;
        logic             nd_neg;
        logic [SQ_W-1:0]  d2;
        logic             high;
        logic             zero;
    } t_side_b;

    typedef struct packed {
        logic [OUT_W-1:0] alpha;
        logic             nd_neg;
        logic             high;
        logic             zero;
    } t_side_c;

    // Sign and magnitude to saturated two's complement
    function automatic logic [OUT_W-1:0] sat32(input logic neg, input logic ovf,
                                               input logic [OUT_W-1:0] mag);
        logic [OUT_W-1:0] res;
        if (ovf) begin
            res = neg ? SAT_MIN : SAT_MAX;
        end else if (neg) begin
            res = (mag > SAT_MIN) ? SAT_MIN : OUT_W'(OUT_W'(0) - mag);
        end else begin
            res = (mag > SAT_MAX) ? SAT_MAX : mag;
        end
        return res;
    endfunction

endpackage

### rtl/core/bsc_if.sv
// ----------------------------------------------------------------------------
// Bilinear spring coefficients: channel interfaces
// Item, result and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsc_item_if import bsc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] node_a_ref_x;
    logic signed [COORD_W-1:0] node_a_ref_y;
    logic signed [COORD_W-1:0] node_a_ref_z;
    logic signed [COORD_W-1:0] node_b_ref_x;
    logic signed [COORD_W-1:0] node_b_ref_y;
    logic signed [COORD_W-1:0] node_b_ref_z;
    logic signed [COORD_W-1:0] node_a_cur_x;
    logic signed [COORD_W-1:0] node_a_cur_y;
    logic signed [COORD_W-1:0] node_a_cur_z;
    logic signed [COORD_W-1:0] node_b_cur_x;
    logic signed [COORD_W-1:0] node_b_cur_y;
    logic signed [COORD_W-1:0] node_b_cur_z;

    modport source (
        output valid, node_a_ref_x, node_a_ref_y, node_a_ref_z,
               node_b_ref_x, node_b_ref_y, node_b_ref_z,
               node_a_cur_x, node_a_cur_y, node_a_cur_z,
               node_b_cur_x, node_b_cur_y, node_b_cur_z,
        input  ready
    );
    modport sink (
        input  valid, node_a_ref_x, node_a_ref_y, node_a_ref_z,
               node_b_ref_x, node_b_ref_y, node_b_ref_z,
               node_a_cur_x, node_a_cur_y, node_a_cur_z,
               node_b_cur_x, node_b_cur_y, node_b_cur_z,
        output ready
    );
endinterface

interface bsc_result_if import bsc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] alpha;
    logic signed [OUT_W-1:0] alpha_d;
    logic                    high_regime;
    logic                    zero_length;

    modport source (output valid, alpha, alpha_d, high_regime, zero_length, input ready);
    modport sink   (input valid, alpha, alpha_d, high_regime, zero_length, output ready);
endinterface

interface bsc_cfg_if import bsc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [K_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/bsc_sqdist.sv
// ----------------------------------------------------------------------------
// Bilinear spring coefficients: squared distances
// Difference, square and axis sum for the reference and current segment.
// ----------------------------------------------------------------------------
module bsc_sqdist import bsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_vec              i_ref_a,
    input  t_vec              i_ref_b,
    input  t_vec              i_cur_a,
    input  t_vec              i_cur_b,
    input  logic [AXES_W-1:0] i_axes,
    output logic              o_valid,
    output logic [SUM_W-1:0]  o_sum_ref,
    output logic [SUM_W-1:0]  o_sum_cur
);

    logic [2:0]             r_v;
    logic [DIFF_W-1:0]      r_mag [2][3];
    logic [DIFF_W-1:0]      n_mag [2][3];
    logic [SQ_W-1:0]        r_sq  [2][3];
    logic [SUM_W-1:0]       r_sum [2];

    always_comb begin
        logic signed [DIFF_W-1:0] dr;
        logic signed [DIFF_W-1:0] dc;
        for (int j = 0; j < 3; j++) begin
            dr = $signed({i_ref_a[j][COORD_W-1], i_ref_a[j]})
               - $signed({i_ref_b[j][COORD_W-1], i_ref_b[j]});
            dc = $signed({i_cur_a[j][COORD_W-1], i_cur_a[j]})
               - $signed({i_cur_b[j][COORD_W-1], i_cur_b[j]});
            n_mag[0][j] = dr[DIFF_W-1] ? DIFF_W'(-dr) : DIFF_W'(dr);
            n_mag[1][j] = dc[DIFF_W-1] ? DIFF_W'(-dc) : DIFF_W'(dc);
            // drop axes beyond the active count
            if (AXES_W'(j) >= i_axes) begin
                n_mag[0][j] = '0;
                n_mag[1][j] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                for (int j = 0; j < 3; j++) begin
                    r_mag[l][j] <= n_mag[l][j];
                    r_sq[l][j]  <= SQ_W'(r_mag[l][j]) * SQ_W'(r_mag[l][j]);
                end
                r_sum[l] <= SUM_W'(r_sq[l][0]) + SUM_W'(r_sq[l][1]) + SUM_W'(r_sq[l][2]);
            end
        end
    end

    assign o_valid   = r_v[2];
    assign o_sum_ref = r_sum[0];
    assign o_sum_cur = r_sum[1];

endmodule

### rtl/core/bsc_isqrt.sv
// ----------------------------------------------------------------------------
// Bilinear spring coefficients: integer square root
// Two lanes, one result bit per stage, floor of the root.
// ----------------------------------------------------------------------------
module bsc_isqrt import bsc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [SUM_W-1:0] i_sum_ref,
    input  logic [SUM_W-1:0] i_sum_cur,
    output logic             o_valid,
    output logic [LEN_W-1:0] o_len_ref,
    output logic [LEN_W-1:0] o_len_cur
);

    logic [LEN_W-1:0] r_v;
    logic [SUM_W-1:0] r_rad  [2][LEN_W];
    logic [LEN_W:0]   r_rem  [2][LEN_W];
    logic [LEN_W-1:0] r_root [2][LEN_W];
    logic [SUM_W-1:0] n_rad  [2][LEN_W];
    logic [LEN_W:0]   n_rem  [2][LEN_W];
    logic [LEN_W-1:0] n_root [2][LEN_W];

    always_comb begin
        logic [SUM_W-1:0] rad;
        logic [LEN_W:0]   rem;
        logic [LEN_W-1:0] root;
        logic [LEN_W+2:0] sh;
        logic [LEN_W+2:0] trial;
        logic             ge;
        for (int l = 0; l < 2; l++) begin
            for (int k = 0; k < LEN_W; k++) begin
                if (k == 0) begin
                    rad  = (l == 0) ? i_sum_ref : i_sum_cur;
                    rem  = '0;
                    root = '0;
                end else begin
                    rad  = r_rad[l][k-1];
                    rem  = r_rem[l][k-1];
                    root = r_root[l][k-1];
                end
                // bring down the next pair of radicand bits
                sh    = {rem, rad[SUM_W-1 -: 2]};
                trial = {1'b0, root, 2'b01};
                ge    = (sh >= trial);
                n_rem[l][k]  = ge ? (LEN_W+1)'(sh - trial) : (LEN_W+1)'(sh);
                n_root[l][k] = {root[LEN_W-2:0], ge};
                n_rad[l][k]  = rad << 2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[LEN_W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_valid   = r_v[LEN_W-1];
    assign o_len_ref = r_root[0][LEN_W-1];
    assign o_len_cur = r_root[1][LEN_W-1];

endmodule

### rtl/core/bsc_numer.sv
// ----------------------------------------------------------------------------
// Bilinear spring coefficients: numerators
// Stretch, regime select, stiffness products and signed sums to magnitude.
// ----------------------------------------------------------------------------
module bsc_numer import bsc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [LEN_W-1:0] i_lref,
    input  logic [LEN_W-1:0] i_lcur,
    input  logic [K_W-1:0]   i_kl,
    input  logic [K_W-1:0]   i_kh,
    input  logic [K_W-1:0]   i_cut,
    output logic             o_valid,
    output t_numer           o_numer
);

    localparam int PA_W  = K_W + STR_W;
    localparam int PC_W  = 2 * K_W + 1;
    localparam int ACC_W = PC_W + 2;

    logic [3:0] r_v;

    // stage 1
    logic signed [STR_W-1:0] r1_str;
    logic [LEN_W-1:0]        r1_lref;
    logic [LEN_W-1:0]        r1_lcur;
    logic                    r1_high;
    logic                    r1_zero;
    // stage 2
    logic signed [PA_W-1:0]  r2_pa;
    logic signed [PA_W-1:0]  r2_pd;
    logic signed [PC_W-1:0]  r2_corr;
    logic [LEN_W-1:0]        r2_lcur;
    logic [SQ_W-1:0]         r2_d2;
    logic                    r2_high;
    logic                    r2_zero;
    // stage 3
    logic signed [ACC_W-1:0] r3_sa;
    logic signed [ACC_W-1:0] r3_sd;
    logic [LEN_W-1:0]        r3_lcur;
    logic [SQ_W-1:0]         r3_d2;
    logic                    r3_high;
    logic                    r3_zero;
    // stage 4
    t_numer                  r4;

    logic signed [STR_W-1:0] n_str;
    logic signed [K_W-1:0]   w_k;
    logic signed [K_W:0]     w_kdiff;

    assign n_str   = $signed({1'b0, i_lcur}) - $signed({1'b0, i_lref});
    assign w_k     = r1_high ? $signed(i_kh) : $signed(i_kl);
    assign w_kdiff = $signed({i_kl[K_W-1], i_kl}) - $signed({i_kh[K_W-1], i_kh});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_str  <= n_str;
            r1_lref <= i_lref;
            r1_lcur <= i_lcur;
            r1_high <= !($signed(K_W'(n_str)) < $signed(i_cut));
            r1_zero <= (i_lcur == '0);

            r2_pa   <= w_k * r1_str;
            r2_pd   <= w_k * $signed({1'b0, r1_lref});
            // correction term only applies in the high regime
            r2_corr <= r1_high ? $signed(i_cut) * w_kdiff : $signed(PC_W'(0));
            r2_lcur <= r1_lcur;
            r2_d2   <= SQ_W'(r1_lcur) * SQ_W'(r1_lcur);
            r2_high <= r1_high;
            r2_zero <= r1_zero;

            r3_sa   <= ACC_W'(r2_pa) + ACC_W'(r2_corr);
            r3_sd   <= ACC_W'(r2_pd) - ACC_W'(r2_corr);
            r3_lcur <= r2_lcur;
            r3_d2   <= r2_d2;
            r3_high <= r2_high;
            r3_zero <= r2_zero;

            r4.na_neg <= r3_sa[ACC_W-1];
            r4.na_mag <= r3_sa[ACC_W-1] ? NUM_W'(-r3_sa) : NUM_W'(r3_sa);
            r4.nd_neg <= r3_sd[ACC_W-1];
            r4.nd_mag <= r3_sd[ACC_W-1] ? NUM_W'(-r3_sd) : NUM_W'(r3_sd);
            r4.lcur   <= r3_lcur;
            r4.d2     <= r3_d2;
            r4.high   <= r3_high;
            r4.zero   <= r3_zero;
        end
    end

    assign o_valid = r_v[3];
    assign o_numer = r4;

endmodule

### rtl/core/bsc_div.sv
// ----------------------------------------------------------------------------
// Bilinear spring coefficients: pipelined divider
// Restoring division by a segment length, one quotient bit per stage.
// The dividend bits above QB must be below the divisor unless i_ovf is set.
// ----------------------------------------------------------------------------
module bsc_div import bsc_pkg::*; #(
    parameter int DW = 64,
    parameter int QB = 32,
    parameter int SW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [DW-1:0]    i_num,
    input  logic             i_ovf,
    input  logic [LEN_W-1:0] i_div,
    input  logic [SW-1:0]    i_side,
    output logic             o_valid,
    output logic [QB-1:0]    o_quo,
    output logic             o_ovf,
    output logic [LEN_W-1:0] o_div,
    output logic [SW-1:0]    o_side
);

    logic [QB:0]        r_v;
    logic [LEN_W-1:0]   r_rem  [QB+1];
    logic [QB-1:0]      r_lo   [QB+1];
    logic               r_ovf  [QB+1];
    logic [LEN_W-1:0]   r_d    [QB+1];
    logic [SW-1:0]      r_side [QB+1];
    logic [LEN_W-1:0]   n_rem  [QB+1];
    logic [QB-1:0]      n_lo   [QB+1];

    always_comb begin
        logic [LEN_W:0] sh;
        logic           ge;
        n_rem[0] = LEN_W'(i_num >> QB);
        n_lo[0]  = i_num[QB-1:0];
        for (int k = 1; k <= QB; k++) begin
            sh = {r_rem[k-1], r_lo[k-1][QB-1]};
            ge = (sh >= {1'b0, r_d[k-1]});
            n_rem[k] = ge ? LEN_W'(sh - {1'b0, r_d[k-1]}) : LEN_W'(sh);
            // shift the quotient bit in behind the dividend bits
            n_lo[k]  = {r_lo[k-1][QB-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QB-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem     <= n_rem;
            r_lo      <= n_lo;
            r_ovf[0]  <= i_ovf;
            r_d[0]    <= i_div;
            r_side[0] <= i_side;
            for (int k = 1; k <= QB; k++) begin
                r_ovf[k]  <= r_ovf[k-1];
                r_d[k]    <= r_d[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_v[QB];
    assign o_quo   = r_lo[QB];
    assign o_ovf   = r_ovf[QB];
    assign o_div   = r_d[QB];
    assign o_side  = r_side[QB];

endmodule

### rtl/core/bilinear_spring_coefficients.sv
// ----------------------------------------------------------------------------
// Bilinear spring coefficients: top level
// Force and derivative coefficients of a spring with a stiffness cutoff.
// ----------------------------------------------------------------------------
// The block takes one spring per clock while the output is not stalled and
// returns one result per spring, in order. The path runs through squared
// distances, the 25-bit square root at one root bit per stage, the numerators,
// then four chained dividers at one quotient bit per stage: alpha (32 bits),
// the first division for alpha_d (64 bits), the rescaled second (FRAC_BITS +
// 25 bits) and the third (32 bits), each behind an input register, plus the
// output register. Every stage advances together whenever the output
// register is empty or being taken. Registers may be written only
// while no spring is in flight.
module bilinear_spring_coefficients import bsc_pkg::*; #(
    parameter int MAX_AXES  = 3,
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bsc_item_if.sink     i_item,
    bsc_cfg_if.sink      i_cfg,
    bsc_result_if.source o_result
);

    localparam int Q2_W = FRAC_BITS + LEN_W;
    localparam int D2_W = SQ_W + FRAC_BITS;
    localparam int D3_W = Q2_W + FRAC_BITS;

    // register file
    logic [K_W-1:0]    r_kl;
    logic [K_W-1:0]    r_kh;
    logic [K_W-1:0]    r_cut;
    logic [AXES_W-1:0] r_axes;
    logic [AXES_W-1:0] w_axes;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kl   <= RST_STIFFNESS;
            r_kh   <= RST_STIFFNESS;
            r_cut  <= RST_CUTOFF;
            r_axes <= RST_AXES;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_LOW_STIFFNESS:  r_kl   <= i_cfg.data;
                REG_HIGH_STIFFNESS: r_kh   <= i_cfg.data;
                REG_CUTOFF_STRETCH: r_cut  <= i_cfg.data;
                REG_AXIS_COUNT:     r_axes <= i_cfg.data[AXES_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_axes = (r_axes > AXES_W'(MAX_AXES)) ? AXES_W'(MAX_AXES) : r_axes;

    // global advance
    logic r_out_valid;
    logic w_en;

    assign w_en         = !r_out_valid || o_result.ready;
    assign i_item.ready = w_en;

    t_vec w_ref_a, w_ref_b, w_cur_a, w_cur_b;

    assign w_ref_a = {i_item.node_a_ref_z, i_item.node_a_ref_y, i_item.node_a_ref_x};
    assign w_ref_b = {i_item.node_b_ref_z, i_item.node_b_ref_y, i_item.node_b_ref_x};
    assign w_cur_a = {i_item.node_a_cur_z, i_item.node_a_cur_y, i_item.node_a_cur_x};
    assign w_cur_b = {i_item.node_b_cur_z, i_item.node_b_cur_y, i_item.node_b_cur_x};

    logic             w_sq_valid;
    logic [SUM_W-1:0] w_sum_ref, w_sum_cur;

    bsc_sqdist u_sqdist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_item.valid),
        .i_ref_a   (w_ref_a),
        .i_ref_b   (w_ref_b),
        .i_cur_a   (w_cur_a),
        .i_cur_b   (w_cur_b),
        .i_axes    (w_axes),
        .o_valid   (w_sq_valid),
        .o_sum_ref (w_sum_ref),
        .o_sum_cur (w_sum_cur)
    );

    logic             w_len_valid;
    logic [LEN_W-1:0] w_lref, w_lcur;

    bsc_isqrt u_isqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_sq_valid),
        .i_sum_ref (w_sum_ref),
        .i_sum_cur (w_sum_cur),
        .o_valid   (w_len_valid),
        .o_len_ref (w_lref),
        .o_len_cur (w_lcur)
    );

    logic   w_num_valid;
    t_numer w_num;

    bsc_numer u_numer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_len_valid),
        .i_lref  (w_lref),
        .i_lcur  (w_lcur),
        .i_kl    (r_kl),
        .i_kh    (r_kh),
        .i_cut   (r_cut),
        .o_valid (w_num_valid),
        .o_numer (w_num)
    );

    // alpha = na / Lc
    t_side_a          w_sa_in, w_sa_out;
    logic             w_da_valid, w_da_ovf;
    logic [OUT_W-1:0] w_da_quo;
    logic [LEN_W-1:0] w_da_div;
    logic             w_da_ovf_in;

    assign w_sa_in     = '{nd_neg: w_num.nd_neg, nd_mag: w_num.nd_mag, d2: w_num.d2,
                           high: w_num.high, zero: w_num.zero, na_neg: w_num.na_neg};
    assign w_da_ovf_in = (w_num.na_mag >= NUM_W'({w_num.lcur, OUT_W'(0)}));

    bsc_div #(.DW(NUM_W), .QB(OUT_W), .SW($bits(t_side_a))) u_div_alpha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_num_valid),
        .i_num   (w_num.na_mag),
        .i_ovf   (w_da_ovf_in),
        .i_div   (w_num.lcur),
        .i_side  (w_sa_in),
        .o_valid (w_da_valid),
        .o_quo   (w_da_quo),
        .o_ovf   (w_da_ovf),
        .o_div   (w_da_div),
        .o_side  (w_sa_out)
    );

    // first division of the derivative numerator
    t_side_b          w_sb_in, w_sb_out;
    logic             w_d1_valid;
    logic [NUM_W-1:0] w_q1;
    logic [LEN_W-1:0] w_d1_div;

    assign w_sb_in = '{alpha: sat32(w_sa_out.na_neg, w_da_ovf, w_da_quo),
                       nd_neg: w_sa_out.nd_neg, d2: w_sa_out.d2,
                       high: w_sa_out.high, zero: w_sa_out.zero};

    bsc_div #(.DW(NUM_W), .QB(NUM_W), .SW($bits(t_side_b))) u_div_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_da_valid),
        .i_num   (w_sa_out.nd_mag),
        .i_ovf   (1'b0),
        .i_div   (w_da_div),
        .i_side  (w_sb_in),
        .o_valid (w_d1_valid),
        .o_quo   (w_q1),
        .o_ovf   (),
        .o_div   (w_d1_div),
        .o_side  (w_sb_out)
    );

    // second division, rescaled; the result saturates once q1 reaches Lc^2
    t_side_c          w_sc_in, w_sc_out;
    logic             w_d2_valid, w_d2_ovf, w_d2_ovf_in;
    logic [Q2_W-1:0]  w_q2;
    logic [LEN_W-1:0] w_d2_div;
    logic [D2_W-1:0]  w_d2_num;

    assign w_sc_in     = '{alpha: w_sb_out.alpha, nd_neg: w_sb_out.nd_neg,
                           high: w_sb_out.high, zero: w_sb_out.zero};
    assign w_d2_ovf_in = (w_q1 >= NUM_W'(w_sb_out.d2));
    assign w_d2_num    = {w_q1[SQ_W-1:0], {FRAC_BITS{1'b0}}};

    bsc_div #(.DW(D2_W), .QB(Q2_W), .SW($bits(t_side_c))) u_div_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d1_valid),
        .i_num   (w_d2_num),
        .i_ovf   (w_d2_ovf_in),
        .i_div   (w_d1_div),
        .i_side  (w_sc_in),
        .o_valid (w_d2_valid),
        .o_quo   (w_q2),
        .o_ovf   (w_d2_ovf),
        .o_div   (w_d2_div),
        .o_side  (w_sc_out)
    );

    // third division; saturate once q2 reaches Lc * 2^(32 - FRAC_BITS)
    t_side_c          w_sd_out;
    logic             w_d3_valid, w_d3_ovf, w_d3_ovf_in;
    logic [OUT_W-1:0] w_d3_quo;
    logic [D3_W-1:0]  w_d3_num;

    assign w_d3_ovf_in = w_d2_ovf
                      || (NUM_W'(w_q2) >= (NUM_W'(w_d2_div) << (OUT_W - FRAC_BITS)));
    assign w_d3_num    = {w_q2, {FRAC_BITS{1'b0}}};

    bsc_div #(.DW(D3_W), .QB(OUT_W), .SW($bits(t_side_c))) u_div_third (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d2_valid),
        .i_num   (w_d3_num),
        .i_ovf   (w_d3_ovf_in),
        .i_div   (w_d2_div),
        .i_side  (w_sc_out),
        .o_valid (w_d3_valid),
        .o_quo   (w_d3_quo),
        .o_ovf   (w_d3_ovf),
        .o_div   (),
        .o_side  (w_sd_out)
    );

    // output register
    logic [OUT_W-1:0] r_alpha, r_alpha_d;
    logic             r_high, r_zero;
    logic [OUT_W-1:0] n_alpha_d;

    assign n_alpha_d = sat32(w_sd_out.nd_neg && (w_d3_ovf || (w_d3_quo != '0)),
                             w_d3_ovf, w_d3_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_d3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // zero current length forces both coefficients to zero
            r_alpha   <= w_sd_out.zero ? '0 : w_sd_out.alpha;
            r_alpha_d <= w_sd_out.zero ? '0 : n_alpha_d;
            r_high    <= w_sd_out.high;
            r_zero    <= w_sd_out.zero;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.alpha       = r_alpha;
    assign o_result.alpha_d     = r_alpha_d;
    assign o_result.high_regime = r_high;
    assign o_result.zero_length = r_zero;

    a_zero_len_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.zero_length |->
            (o_result.alpha == '0) && (o_result.alpha_d == '0))
        else $error("zero length result carries nonzero coefficients");

    a_stall_holds_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_d3_valid) && $stable(w_d3_quo) && $stable(w_d3_ovf))
        else $error("pipeline tail moved during a stall");

endmodule

### verif/bsc_test_if.sv
// ----------------------------------------------------------------------------
// Bilinear spring coefficients: testbench channel notes
// The channel interfaces come from the RTL; this file holds the test-side
// spring request and coefficient result records used by the scoreboard and the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package bsc_test_pkg;
    import bsc_pkg::*;

    typedef struct {
        logic signed [COORD_W-1:0] c [12];
    } t_spring;

    typedef struct {
        logic signed [OUT_W-1:0] alpha;
        logic signed [OUT_W-1:0] alpha_d;
        logic                    high;
        logic                    zero;
    } t_coeffs;
endpackage

### verif/bilinear_spring_coefficients_test.sv
// ----------------------------------------------------------------------------
// Bilinear spring coefficients: block test
// Drives springs with random gaps and register writes between phases, predicts
// alpha, alpha_d and the flags in fixed point, and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bilinear_spring_coefficients_test;
    import bsc_pkg::*;
    import bsc_test_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 190 + FRAC;

    class coeff_scoreboard;
        logic [31:0] k_low, k_high, cutoff;
        logic [1:0]  axes;
        t_coeffs     pending[$];
        int          errors;

        function new();
            k_low = 32'd65536; k_high = 32'd65536; cutoff = 0; axes = 3;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                REG_LOW_STIFFNESS:  k_low = val;
                REG_HIGH_STIFFNESS: k_high = val;
                REG_CUTOFF_STRETCH: cutoff = val;
                REG_AXIS_COUNT:     axes = val[1:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] root(logic [63:0] v);
            logic [63:0] r, b;
            r = 0; b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b; r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function logic [63:0] rescale_div(logic [63:0] m, logic [63:0] d);
            logic [63:0] q, r;
            q = m / d; r = m % d;
            if (q >= (64'd1 << (62 - FRAC))) return 64'd1 << 62;
            q <<= FRAC;
            for (int i = FRAC - 1; i >= 0; i--) begin
                r <<= 1;
                if (r >= d) begin
                    r -= d; q[i] = 1'b1;
                end
            end
            return q;
        endfunction

        function logic [31:0] saturate(bit neg, logic [63:0] mag);
            if (neg) return (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
            return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        endfunction

        // signed 64-bit product as sign and magnitude
        function void mul_sm(longint a, longint b, output bit neg,
                             output logic [63:0] mag);
            logic [63:0] ua, ub;
            ua = a < 0 ? -a : a; ub = b < 0 ? -b : b;
            mag = ua * ub;
            neg = ((a < 0) != (b < 0)) && mag != 0;
        endfunction

        function void add_sm(bit an, logic [63:0] am, bit bn, logic [63:0] bm,
                             output bit rn, output logic [63:0] rm);
            if (an == bn) begin
                rm = am + bm; rn = an;
            end else if (am >= bm) begin
                rm = am - bm; rn = an;
            end else begin
                rm = bm - am; rn = bn;
            end
            if (rm == 0) rn = 0;
        endfunction

        function logic [63:0] seg(t_spring s, int a, int b, int n);
            logic [63:0] sum;
            longint d;
            sum = 0;
            for (int i = 0; i < n; i++) begin
                d = longint'(s.c[a + i]) - longint'(s.c[b + i]);
                if (d < 0) d = -d;
                sum += d * d;
            end
            return root(sum);
        endfunction

        function void note_spring(t_spring s);
            t_coeffs     e;
            int          n;
            longint      kl, kh, cut, stretch;
            logic [63:0] lref, lcur, am, dm, cm, tm, q;
            bit          an, dn, cn, tn;
            n = (axes > 3) ? 3 : axes;
            kl = longint'($signed(k_low)); kh = longint'($signed(k_high));
            cut = longint'($signed(cutoff));
            lref = seg(s, 0, 3, n); lcur = seg(s, 6, 9, n);
            stretch = longint'(lcur) - longint'(lref);
            e.high = !(stretch < cut);
            e.zero = (lcur == 0);
            e.alpha = 0; e.alpha_d = 0;
            if (!e.zero) begin
                if (!e.high) begin
                    mul_sm(kl, stretch, an, am);
                    mul_sm(kl, longint'(lref), dn, dm);
                end else begin
                    mul_sm(cut, kl - kh, cn, cm);
                    mul_sm(kh, stretch, tn, tm);
                    add_sm(tn, tm, cn, cm, an, am);
                    mul_sm(kh, longint'(lref), tn, tm);
                    add_sm(tn, tm, (cm != 0) ? !cn : cn, cm, dn, dm);
                end
                e.alpha = saturate(an, am / lcur);
                q = rescale_div(rescale_div(dm / lcur, lcur), lcur);
                e.alpha_d = saturate(dn && q != 0, q);
            end
            pending.push_back(e);
        endfunction

        function void check(t_coeffs got);
            t_coeffs e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result alpha %h", $time, got.alpha);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.alpha !== e.alpha) begin
                $display("%0t: alpha exp %h got %h", $time, e.alpha, got.alpha);
                errors++;
            end
            if (got.alpha_d !== e.alpha_d) begin
                $display("%0t: alpha_d exp %h got %h", $time, e.alpha_d, got.alpha_d);
                errors++;
            end
            if (got.high !== e.high) begin
                $display("%0t: high_regime exp %b got %b", $time, e.high, got.high);
                errors++;
            end
            if (got.zero !== e.zero) begin
                $display("%0t: zero_length exp %b got %b", $time, e.zero, got.zero);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    bsc_item_if   item_ch();
    bsc_cfg_if    cfg_ch();
    bsc_result_if res_ch();
    coeff_scoreboard sb;
    bit sink_on;

    bilinear_spring_coefficients u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item(item_ch.sink), .i_cfg(cfg_ch.sink), .o_result(res_ch.source)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("** bilinear_spring_coefficients: FAILED **");
        $finish;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stalls, check on each accepted result
    always @(posedge i_clk) begin
        t_coeffs got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.alpha = res_ch.alpha; got.alpha_d = res_ch.alpha_d;
            got.high = res_ch.high_regime; got.zero = res_ch.zero_length;
            sb.check(got);
        end
        res_ch.ready <= sink_on ? ($urandom_range(0, 99) < 70) : 1'b1;
    end

    // valid stays high across back-to-back requests; drop it only for a gap
    task automatic send_spring(t_spring s);
        int gap;
        gap = gap_len();
        cfg_ch.valid <= 0;
        if (gap > 0) begin
            item_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid <= 1;
        {item_ch.node_a_ref_x, item_ch.node_a_ref_y, item_ch.node_a_ref_z} <=
            {s.c[0], s.c[1], s.c[2]};
        {item_ch.node_b_ref_x, item_ch.node_b_ref_y, item_ch.node_b_ref_z} <=
            {s.c[3], s.c[4], s.c[5]};
        {item_ch.node_a_cur_x, item_ch.node_a_cur_y, item_ch.node_a_cur_z} <=
            {s.c[6], s.c[7], s.c[8]};
        {item_ch.node_b_cur_x, item_ch.node_b_cur_y, item_ch.node_b_cur_z} <=
            {s.c[9], s.c[10], s.c[11]};
        do @(posedge i_clk); while (!item_ch.ready);
        sb.note_spring(s);
    endtask

    // hold valid for a following write; the next spring request drops it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_ch.valid <= 1; cfg_ch.index <= idx; cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, val);
    endtask

    // wait for every pending result, then let the pipeline drain
    task automatic drain(int limit);
        int n;
        n = 0;
        item_ch.valid <= 0;
        while (sb.pending.size() != 0 && n < limit) begin
            @(posedge i_clk); n++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic [COORD_W-1:0] rand_coord(int mode);
        case (mode)
            0: return COORD_W'($urandom);
            1: return COORD_W'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            default: return COORD_W'($signed($urandom_range(0, 1 << 13)) - (1 << 12));
        endcase
    endfunction

    function automatic t_spring rand_spring();
        t_spring s;
        int m;
        m = $urandom_range(0, 2);
        for (int i = 0; i < 12; i++) s.c[i] = rand_coord(m);
        // sometimes collapse the current segment
        if ($urandom_range(0, 15) == 0)
            for (int i = 0; i < 3; i++) s.c[9 + i] = s.c[6 + i];
        return s;
    endfunction

    function automatic logic [31:0] rand_k();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        endcase
    endfunction

    function automatic logic [31:0] rand_cut();
        if ($urandom_range(0, 1)) return rand_k();
        return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
    endfunction

    initial begin
        t_spring s;
        sb = new();
        sink_on = 0;
        i_rst_n = 0;
        item_ch.valid = 0;
        {item_ch.node_a_ref_x, item_ch.node_a_ref_y, item_ch.node_a_ref_z} = '0;
        {item_ch.node_b_ref_x, item_ch.node_b_ref_y, item_ch.node_b_ref_z} = '0;
        {item_ch.node_a_cur_x, item_ch.node_a_cur_y, item_ch.node_a_cur_z} = '0;
        {item_ch.node_b_cur_x, item_ch.node_b_cur_y, item_ch.node_b_cur_z} = '0;
        cfg_ch.valid = 0; cfg_ch.index = '0; cfg_ch.data = '0;
        res_ch.ready = 1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, zero length, both regimes, reset registers
        for (int k = 0; k < 12; k++) s.c[k] = 0;
        send_spring(s);
        for (int k = 0; k < 12; k++) s.c[k] = (k % 6 < 3) ? 24'h7FFFFF : 24'h800000;
        send_spring(s);
        for (int k = 0; k < 12; k++)
            s.c[k] = (k < 6) ? 24'h0 : ((k % 6 < 3) ? 24'h800000 : 24'h7FFFFF);
        send_spring(s);
        for (int k = 0; k < 12; k++) s.c[k] = 0;
        s.c[3] = 24'h030000; s.c[9] = 24'h010000;
        send_spring(s);
        s.c[3] = 24'h010000; s.c[9] = 24'h030000;
        send_spring(s);
        s.c[9] = 24'h000001;
        send_spring(s);
        for (int k = 0; k < 6; k++) send_spring(rand_spring());
        sink_on = 1;
        drain(100000);

        // out-of-range index, axis count zero, extremes of the registers
        write_reg(CFG_IDX_W'(7), 32'hFFFF_FFFF);
        write_reg(REG_AXIS_COUNT, 32'd0);
        for (int k = 0; k < 3; k++) send_spring(rand_spring());
        drain(100000);
        write_reg(REG_AXIS_COUNT, 32'd3);
        write_reg(REG_LOW_STIFFNESS, 32'h7FFF_FFFF);
        write_reg(REG_HIGH_STIFFNESS, 32'h8000_0000);
        write_reg(REG_CUTOFF_STRETCH, 32'h8000_0000);
        for (int k = 0; k < 4; k++) send_spring(rand_spring());
        drain(100000);
        write_reg(REG_CUTOFF_STRETCH, 32'h7FFF_FFFF);
        for (int k = 0; k < 4; k++) send_spring(rand_spring());
        drain(100000);

        // random phases, each with its own register setting
        for (int ph = 0; ph < 16; ph++) begin
            write_reg(REG_LOW_STIFFNESS, rand_k());
            write_reg(REG_HIGH_STIFFNESS, rand_k());
            write_reg(REG_CUTOFF_STRETCH, rand_cut());
            write_reg(REG_AXIS_COUNT, $urandom_range(0, 3));
            for (int k = 0; k < 40; k++) send_spring(rand_spring());
            drain(200000);
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("** bilinear_spring_coefficients: PASSED **");
        end else begin
            $display("** bilinear_spring_coefficients: FAILED **");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/core/bsc_pkg.sv
rtl/core/bsc_if.sv
rtl/core/bsc_sqdist.sv
rtl/core/bsc_isqrt.sv
rtl/core/bsc_numer.sv
rtl/core/bsc_div.sv
rtl/core/bilinear_spring_coefficients.sv
verif/bsc_test_if.sv
verif/bilinear_spring_coefficients_test.sv
